[src/sld_pkg.sv]
// Shared types and constants for the STX/ETX deframer with XOR LRC.
// Holds result status codes, register indexes and controller/datapath structs.
package sld_pkg;

  localparam int MAX_PAYLOAD_DEF = 8;
  localparam logic [7:0] START_CODE_RST = 8'h02;
  localparam logic [7:0] END_CODE_RST = 8'h03;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_CODE = 2'd0,
    REG_END_CODE   = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_LRC  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic    clr_frame;
    logic    store;
    logic    fold_end;
    logic    idx_clr;
    logic    idx_inc;
    logic    out_data;
    logic    out_status;
    status_t status_code;
  } cmd_t;

  typedef struct packed {
    logic eq_start;
    logic eq_end;
    logic lrc_match;
    logic count_full;
    logic count_zero;
    logic idx_last;
    logic out_busy;
  } sts_t;

endpackage

[src/sld_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/sld_dp.sv]
// Deframer datapath: code registers, byte count, running LRC, payload RAM
// and the output register. Depends on sld_pkg and sld_ram.
module sld_dp
  import sld_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic [7:0]           rx_byte,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [7:0]           data_byte,
  output logic [1:0]           status,
  output logic                 last
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW = $clog2(MAX_PAYLOAD + 1);

  logic [7:0]    start_code;
  logic [7:0]    end_code;
  logic [CW-1:0] count;
  logic [7:0]    lrc;
  logic [AW-1:0] idx;
  logic [7:0]    rdata;

  sld_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk  (clk),
    .we   (cmd.store),
    .waddr(count[AW-1:0]),
    .wdata(rx_byte),
    .raddr(idx),
    .rdata(rdata)
  );

  always_comb begin
    sts.eq_start   = (rx_byte == start_code);
    sts.eq_end     = (rx_byte == end_code);
    sts.lrc_match  = (rx_byte == lrc);
    sts.count_full = (count == CW'(MAX_PAYLOAD));
    sts.count_zero = (count == '0);
    sts.idx_last   = ((CW'(idx) + CW'(1)) == count);
    sts.out_busy   = out_valid && out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code <= START_CODE_RST;
      end_code   <= END_CODE_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_START_CODE) begin
        start_code <= cfg_data;
      end else if (cfg_index == REG_END_CODE) begin
        end_code <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      lrc   <= '0;
      idx   <= '0;
    end else begin
      if (cmd.clr_frame) begin
        count <= '0;
        lrc   <= '0;
      end else if (cmd.store) begin
        count <= count + CW'(1);
        lrc   <= lrc ^ rx_byte;
      end else if (cmd.fold_end) begin
        lrc <= lrc ^ rx_byte;
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_status || cmd.out_data) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_status) begin
      data_byte <= 8'h00;
      status    <= cmd.status_code;
      last      <= 1'b1;
    end else if (cmd.out_data) begin
      data_byte <= rdata;
      status    <= ST_DATA;
      last      <= sts.idx_last;
    end
  end

endmodule

[src/sld_ctrl.sv]
// Deframer controller: hunt, collect, LRC check and payload readout sequencing.
// Depends on sld_pkg; drives commands to sld_dp and the input stall.
module sld_ctrl
  import sld_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    S_HUNT     = 5'b00001,
    S_COLLECT  = 5'b00010,
    S_WAIT_LRC = 5'b00100,
    S_EMIT_RD  = 5'b01000,
    S_EMIT_WR  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   ready;
  logic   accept;

  assign ready    = (state == S_HUNT || state == S_COLLECT || state == S_WAIT_LRC) &&
                    !sts.out_busy;
  assign accept   = in_valid && ready;
  assign in_stall = !ready;

  always_comb begin
    cmd        = '0;
    cmd.status_code = ST_DATA;
    state_next = state;
    unique case (state)
      S_HUNT: begin
        if (accept && sts.eq_start) begin
          cmd.clr_frame = 1'b1;
          state_next    = S_COLLECT;
        end
      end
      S_COLLECT: begin
        if (accept) begin
          priority if (sts.eq_end) begin
            cmd.fold_end = 1'b1;
            state_next   = S_WAIT_LRC;
          end else if (!sts.count_full) begin
            cmd.store = 1'b1;
          end else begin
            cmd.out_status  = 1'b1;
            cmd.status_code = ST_OVERFLOW;
            cmd.clr_frame   = 1'b1;
            state_next      = S_HUNT;
          end
        end
      end
      S_WAIT_LRC: begin
        if (accept) begin
          priority if (!sts.lrc_match) begin
            cmd.out_status  = 1'b1;
            cmd.status_code = ST_BAD_LRC;
            cmd.clr_frame   = 1'b1;
            state_next      = S_HUNT;
          end else if (sts.count_zero) begin
            cmd.out_status  = 1'b1;
            cmd.status_code = ST_EMPTY;
            cmd.clr_frame   = 1'b1;
            state_next      = S_HUNT;
          end else begin
            cmd.idx_clr = 1'b1;
            state_next  = S_EMIT_RD;
          end
        end
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (!sts.out_busy) begin
          cmd.out_data = 1'b1;
          if (sts.idx_last) begin
            cmd.clr_frame = 1'b1;
            state_next    = S_HUNT;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT;
    end else begin
      state <= state_next;
    end
  end

endmodule

[src/stx_etx_lrc_deframer.sv]
// Top level of the STX/ETX deframer with XOR LRC check.
// Depends on sld_pkg, sld_ctrl, sld_dp and sld_ram.
//
// Received bytes are taken one per cycle while hunting, collecting payload or
// awaiting the LRC byte, provided the output register is free to take a result.
// A frame of N verified payload bytes is then read out of the payload RAM
// one byte at a time (registered RAM read, then output register load), so
// no input beat is taken after the LRC byte until the whole payload, plus any
// output stall, has been read out; the first payload beat shows after that
// RAM read and output register load. Error and empty-frame results are
// loaded into the output register by the accepting edge itself and show on
// the next cycle. Start and end codes are writable at any time the block is
// idle; the config port never stalls.
module stx_etx_lrc_deframer
  import sld_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           data_byte,
  output logic [1:0]           status,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  sld_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  sld_dp #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .rx_byte  (rx_byte),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .data_byte(data_byte),
    .status   (status),
    .last     (last)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_when_out_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !(out_valid && out_stall))
    else $error("input beat accepted while output beat is stalled");

  a_load_shows_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_data || cmd.out_status) |=> out_valid)
    else $error("result load did not raise output valid");

  a_store_below_limit: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> !sts.count_full)
    else $error("payload store written past its depth");
`endif

endmodule
